// ----- src/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere/box collision test package
// Shared widths, shape and pair codes for the collision test pipeline.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Default lane width of one coordinate or size in the packed words.
  localparam int COORD_BITS_DEF = 16;

  // Fixed widths of the packed stream fields.
  localparam int WORD_BITS     = 48;
  localparam int IN_DATA_BITS  = 4 * WORD_BITS;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 8;
  localparam int OUT_USER_BITS = 2;

  typedef enum logic {
    SHAPE_SPHERE = 1'b0,
    SHAPE_BOX    = 1'b1
  } shape_e;

  typedef enum logic [1:0] {
    PC_SPHERE_BOX    = 2'd0,
    PC_SPHERE_SPHERE = 2'd1,
    PC_BOX_BOX       = 2'd2
  } pair_case_e;

endpackage

// ----- src/sphere_box_collision_test.sv -----
// ----------------------------------------------------------------------------
// Sphere/box collision test
// Strict overlap test between two objects, each a sphere or an axis-aligned
// box, evaluated in a four-stage pipeline.
// ----------------------------------------------------------------------------
// One object pair enters per cycle while ready is high; its result moves through
// the input operand stage, clamp stage, square stage and sum-and-compare output
// register. Stages advance independently, so the pipeline only stops taking
// beats when all four stages hold a result and the output side is stalled;
// the ready path is a short combinational chain through the stage valid bits.
// Coordinates are signed lanes of COORD_BITS bits, sizes unsigned lanes of the
// same width; every comparison is exact integer math, so the fixed-point
// scale has no effect on the result. Bits of a word above its three lanes
// are ignored.
module sphere_box_collision_test #(
  parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side. tdata, from bit 0: first_position, second_position,
  // first_size, second_size (48 bits each).
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [sbc_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  // tuser, from bit 0: first_shape, second_shape.
  input  logic [sbc_pkg::IN_USER_BITS-1:0]   s_axis_tuser_i,
  // Master side. tdata, from bit 0: hit, then zero fill.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sbc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata_o,
  // tuser, from bit 0: pair_case.
  output logic [sbc_pkg::OUT_USER_BITS-1:0]  m_axis_tuser_o
);
  import sbc_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int ExtW  = (3 * CW > WORD_BITS) ? 3 * CW : WORD_BITS;
  localparam int DW    = CW + 3;        // signed clamp offsets and differences
  localparam int EW    = CW + 1;        // summed extents
  localparam int RW    = CW + 1;        // doubled radius or radius sum
  localparam int SQW   = 2 * DW;
  localparam int RSQW  = 2 * RW;
  localparam int SUMW  = SQW + 2;

  // --------------------------------------------------------------------------
  // Handshake chain
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !s4_v_q || m_axis_tready_i;
  assign adv3 = !s3_v_q || adv4;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;
  assign s_axis_tready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= s_axis_tvalid_i;
      if (adv2) s2_v_q <= s1_v_q;
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) s4_v_q <= s3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick roles and form per-axis operands
  // --------------------------------------------------------------------------
  logic [ExtW-1:0] fp_w, sp_w, fs_w, ss_w;
  logic [ExtW-1:0] sph_p_w, sph_s_w, box_p_w, box_s_w;
  logic            first_box, second_box;
  pair_case_e      pc_d;

  assign fp_w = ExtW'(s_axis_tdata_i[0*WORD_BITS +: WORD_BITS]);
  assign sp_w = ExtW'(s_axis_tdata_i[1*WORD_BITS +: WORD_BITS]);
  assign fs_w = ExtW'(s_axis_tdata_i[2*WORD_BITS +: WORD_BITS]);
  assign ss_w = ExtW'(s_axis_tdata_i[3*WORD_BITS +: WORD_BITS]);

  assign first_box  = (s_axis_tuser_i[0] == SHAPE_BOX);
  assign second_box = (s_axis_tuser_i[1] == SHAPE_BOX);

  always_comb begin
    sph_p_w = fp_w;
    sph_s_w = fs_w;
    box_p_w = sp_w;
    box_s_w = ss_w;
    if (!first_box && second_box) begin
      pc_d = PC_SPHERE_BOX;
    end else if (first_box && !second_box) begin
      pc_d    = PC_SPHERE_BOX;
      sph_p_w = sp_w;
      sph_s_w = ss_w;
      box_p_w = fp_w;
      box_s_w = fs_w;
    end else if (!first_box) begin
      pc_d = PC_SPHERE_SPHERE;
    end else begin
      pc_d = PC_BOX_BOX;
    end
  end

  logic signed [DW-1:0] s1_c_d  [3];
  logic signed [DW-1:0] s1_lo_d [3];
  logic signed [DW-1:0] s1_hi_d [3];
  logic [EW-1:0]        s1_ext_d [3];
  logic [RW-1:0]        s1_rad_d;

  logic signed [DW-1:0] s1_c_q  [3];
  logic signed [DW-1:0] s1_lo_q [3];
  logic signed [DW-1:0] s1_hi_q [3];
  logic [EW-1:0]        s1_ext_q [3];
  logic [RW-1:0]        s1_rad_q;
  pair_case_e           s1_pc_q;

  always_comb begin
    logic signed [CW-1:0] sc, bc, p1, p2;
    logic [CW-1:0]        be, e1, e2;
    logic signed [DW-1:0] b2, be_s;
    for (int k = 0; k < 3; k++) begin
      sc   = $signed(sph_p_w[k*CW +: CW]);
      bc   = $signed(box_p_w[k*CW +: CW]);
      be   = box_s_w[k*CW +: CW];
      p1   = $signed(fp_w[k*CW +: CW]);
      p2   = $signed(sp_w[k*CW +: CW]);
      e1   = fs_w[k*CW +: CW];
      e2   = ss_w[k*CW +: CW];
      // Centers are doubled so the box half extent stays an integer.
      b2   = DW'(bc) <<< 1;
      be_s = $signed(DW'(be));
      s1_lo_d[k]  = b2 - be_s;
      s1_hi_d[k]  = b2 + be_s;
      s1_c_d[k]   = (pc_d == PC_SPHERE_BOX) ? (DW'(sc) <<< 1) : (DW'(p1) - DW'(p2));
      s1_ext_d[k] = EW'(e1) + EW'(e2);
    end
    if (pc_d == PC_SPHERE_BOX) begin
      s1_rad_d = {sph_s_w[CW-1:0], 1'b0};
    end else begin
      s1_rad_d = RW'(fs_w[CW-1:0]) + RW'(ss_w[CW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid_i) begin
      s1_c_q   <= s1_c_d;
      s1_lo_q  <= s1_lo_d;
      s1_hi_q  <= s1_hi_d;
      s1_ext_q <= s1_ext_d;
      s1_rad_q <= s1_rad_d;
      s1_pc_q  <= pc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clamp into the box, per-axis box test
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s2_dl_d [3];
  logic [2:0]           axis_ok;

  logic signed [DW-1:0] s2_dl_q [3];
  logic [RW-1:0]        s2_rad_q;
  logic                 s2_bb_q;
  pair_case_e           s2_pc_q;

  always_comb begin
    logic signed [DW-1:0] q;
    logic [DW-1:0]        absd;
    for (int k = 0; k < 3; k++) begin
      if (s1_c_q[k] < s1_lo_q[k]) begin
        q = s1_lo_q[k];
      end else if (s1_c_q[k] > s1_hi_q[k]) begin
        q = s1_hi_q[k];
      end else begin
        q = s1_c_q[k];
      end
      s2_dl_d[k] = (s1_pc_q == PC_SPHERE_BOX) ? (q - s1_c_q[k]) : s1_c_q[k];
      absd = s1_c_q[k][DW-1] ? DW'(-s1_c_q[k]) : DW'(s1_c_q[k]);
      axis_ok[k] = ((DW+1)'(absd) << 1) < (DW+1)'(s1_ext_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q) begin
      s2_dl_q  <= s2_dl_d;
      s2_rad_q <= s1_rad_q;
      s2_bb_q  <= &axis_ok;
      s2_pc_q  <= s1_pc_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares
  // --------------------------------------------------------------------------
  logic signed [SQW-1:0] sq_w [3];
  logic [SQW-1:0]        s3_sq_q [3];
  logic [RSQW-1:0]       s3_rsq_q;
  logic                  s3_bb_q;
  pair_case_e            s3_pc_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_w[k] = SQW'(s2_dl_q[k]) * SQW'(s2_dl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_v_q) begin
      for (int k = 0; k < 3; k++) begin
        s3_sq_q[k] <= $unsigned(sq_w[k]);
      end
      s3_rsq_q <= RSQW'(s2_rad_q) * RSQW'(s2_rad_q);
      s3_bb_q  <= s2_bb_q;
      s3_pc_q  <= s2_pc_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum, compare, output register
  // --------------------------------------------------------------------------
  logic [SUMW-1:0] sum_w;
  logic            hit_d;
  logic            s4_hit_q;
  pair_case_e      s4_pc_q;

  assign sum_w = SUMW'(s3_sq_q[0]) + SUMW'(s3_sq_q[1]) + SUMW'(s3_sq_q[2]);
  assign hit_d = (s3_pc_q == PC_BOX_BOX) ? s3_bb_q : (sum_w < SUMW'(s3_rsq_q));

  always_ff @(posedge clk_i) begin
    if (adv4 && s3_v_q) begin
      s4_hit_q <= hit_d;
      s4_pc_q  <= s3_pc_q;
    end
  end

  assign m_axis_tvalid_o = s4_v_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_BITS-1){1'b0}}, s4_hit_q};
  assign m_axis_tuser_o  = s4_pc_q;

`ifndef SYNTHESIS
  // An accepted beat always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> s1_v_q)
    else $error("accepted beat did not reach stage 1");

  // The input side only stalls when every stage is occupied and the output waits.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_v_q && s2_v_q && s3_v_q && s4_v_q && !m_axis_tready_i))
    else $error("input stalled while the pipeline had room");

  // A result leaving stage 3 shows up at the output next cycle.
  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && adv4 |=> m_axis_tvalid_o)
    else $error("stage 3 result lost on the way to the output");
`endif

endmodule

// ----- tb/sv/sphere_box_collision_test_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere/box collision test bench
// Streams object pairs into the collision pipeline with random gaps on the
// input side and random stalls on the output side. Each accepted pair is run
// through an independent overlap predictor, and every result beat is checked
// in order against the queued predictions.
// ----------------------------------------------------------------------------
module sphere_box_collision_test_test;
  import sbc_pkg::*;

  localparam int LANE         = COORD_BITS_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_PAIRS = 700;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic       hit;
    pair_case_e pair_case;
  } overlap_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata_i;
  logic [IN_USER_BITS-1:0]   s_axis_tuser_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata_o;
  logic [OUT_USER_BITS-1:0]  m_axis_tuser_o;

  overlap_t    pending_overlaps[$];
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          send_calm    = 1'b0;
  bit          drain_calm   = 1'b0;

  sphere_box_collision_test u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint coord_of(logic [47:0] w, int k);
    return longint'($signed(w[k*LANE +: LANE]));
  endfunction

  function automatic longint size_of(logic [47:0] w, int k);
    return longint'(w[k*LANE +: LANE]);
  endfunction

  // Works in doubled coordinates so the box half extent stays an integer.
  function automatic logic sphere_box_hit(logic [47:0] sp, logic [47:0] sz,
                                          logic [47:0] bp, logic [47:0] bz);
    longint diam, c, b, e, q, acc;
    acc  = 0;
    diam = 2 * size_of(sz, 0);
    for (int k = 0; k < 3; k++) begin
      c = 2 * coord_of(sp, k);
      b = 2 * coord_of(bp, k);
      e = size_of(bz, k);
      q = c;
      if (q < b - e) q = b - e;
      if (q > b + e) q = b + e;
      acc += (q - c) * (q - c);
    end
    return acc < diam * diam;
  endfunction

  function automatic overlap_t predict_overlap(shape_e s1, shape_e s2,
                                               logic [47:0] p1, logic [47:0] p2,
                                               logic [47:0] z1, logic [47:0] z2);
    overlap_t res;
    longint   d, acc, rsum;
    if (s1 != s2) begin
      res.pair_case = PC_SPHERE_BOX;
      res.hit = (s1 == SHAPE_SPHERE) ? sphere_box_hit(p1, z1, p2, z2)
                                     : sphere_box_hit(p2, z2, p1, z1);
    end else if (s1 == SHAPE_SPHERE) begin
      res.pair_case = PC_SPHERE_SPHERE;
      acc  = 0;
      rsum = size_of(z1, 0) + size_of(z2, 0);
      for (int k = 0; k < 3; k++) begin
        d = coord_of(p1, k) - coord_of(p2, k);
        acc += d * d;
      end
      res.hit = acc < rsum * rsum;
    end else begin
      res.pair_case = PC_BOX_BOX;
      res.hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        d = coord_of(p1, k) - coord_of(p2, k);
        if (d < 0) d = -d;
        if (!(2 * d < size_of(z1, k) + size_of(z2, k))) res.hit = 1'b0;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [47:0] xyz(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  task automatic send_pair(shape_e s1, shape_e s2, logic [47:0] p1, logic [47:0] p2,
                           logic [47:0] z1, logic [47:0] z2);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z2, z1, p2, p1};
    s_axis_tuser_i  <= {s2, s1};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_overlaps.push_back(predict_overlap(s1, s2, p1, p2, z1, z2));
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
  endtask

  task automatic test_sphere_pairs();
    // Zero radii at a common center, then touching and just overlapping.
    send_pair(SHAPE_SPHERE, SHAPE_SPHERE, xyz(0, 0, 0), xyz(0, 0, 0),
              xyz(0, 0, 0), xyz(0, 0, 0));
    send_pair(SHAPE_SPHERE, SHAPE_SPHERE, xyz(0, 0, 0), xyz(10, 0, 0),
              xyz(4, -1, -1), xyz(6, 0, 0));
    send_pair(SHAPE_SPHERE, SHAPE_SPHERE, xyz(0, 0, 0), xyz(10, 0, 0),
              xyz(4, 0, 0), xyz(7, -1, -1));
    send_pair(SHAPE_SPHERE, SHAPE_SPHERE, xyz(-32768, -32768, -32768),
              xyz(32767, 32767, 32767), xyz(65535, 0, 0), xyz(65535, 0, 0));
    send_pair(SHAPE_SPHERE, SHAPE_SPHERE, xyz(-32768, -32768, -32768),
              xyz(32767, 32767, 32767), xyz(65535, 0, 0), xyz(0, 0, 0));
  endtask

  task automatic test_box_pairs();
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(5, 5, 5), xyz(5, 5, 5),
              xyz(0, 0, 0), xyz(0, 0, 0));
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(0, 0, 0), xyz(10, 0, 0),
              xyz(10, 10, 10), xyz(10, 10, 10));
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(0, 0, 0), xyz(10, 0, 0),
              xyz(11, 10, 10), xyz(10, 10, 10));
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(-32768, -32768, -32768),
              xyz(32767, 32767, 32767), xyz(65535, 65535, 65535),
              xyz(65535, 65535, 65535));
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(32767, -32768, 32767),
              xyz(32767, -32768, 32767), xyz(1, 1, 1), xyz(0, 0, 0));
    send_pair(SHAPE_BOX, SHAPE_BOX, xyz(0, 0, 0), xyz(0, 0, 100),
              xyz(300, 300, 50), xyz(300, 300, 50));
  endtask

  task automatic test_sphere_box_pairs();
    // Sphere center inside the box: a zero radius never hits.
    send_pair(SHAPE_SPHERE, SHAPE_BOX, xyz(1, 2, 3), xyz(0, 0, 0),
              xyz(0, -1, -1), xyz(20, 20, 20));
    send_pair(SHAPE_BOX, SHAPE_SPHERE, xyz(0, 0, 0), xyz(1, 2, 3),
              xyz(20, 20, 20), xyz(0, 0, 0));
    send_pair(SHAPE_SPHERE, SHAPE_BOX, xyz(1, 2, 3), xyz(0, 0, 0),
              xyz(1, 0, 0), xyz(20, 20, 20));
    // Sphere touching a face, then reaching past it.
    send_pair(SHAPE_SPHERE, SHAPE_BOX, xyz(15, 0, 0), xyz(0, 0, 0),
              xyz(5, 0, 0), xyz(20, 20, 20));
    send_pair(SHAPE_BOX, SHAPE_SPHERE, xyz(0, 0, 0), xyz(15, 0, 0),
              xyz(20, 20, 20), xyz(6, 0, 0));
    // Near a corner the clamp acts on all three axes.
    send_pair(SHAPE_SPHERE, SHAPE_BOX, xyz(13, 13, 13), xyz(0, 0, 0),
              xyz(5, 0, 0), xyz(20, 20, 20));
    send_pair(SHAPE_BOX, SHAPE_SPHERE, xyz(0, 0, 0), xyz(-13, -13, -13),
              xyz(20, 20, 20), xyz(6, 0, 0));
    send_pair(SHAPE_SPHERE, SHAPE_BOX, xyz(-32768, -32768, -32768),
              xyz(32767, 32767, 32767), xyz(65535, -1, -1),
              xyz(65535, 65535, 65535));
    send_pair(SHAPE_BOX, SHAPE_SPHERE, xyz(32767, 32767, 32767),
              xyz(-32768, -32768, -32768), xyz(0, 0, 0), xyz(65535, 0, 0));
  endtask

  task automatic test_random_pairs();
    shape_e      s1, s2;
    logic [47:0] p1, p2, z1, z2;
    int          base, offs;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      s1 = shape_e'($urandom_range(0, 1));
      s2 = shape_e'($urandom_range(0, 1));
      if ($urandom_range(0, 19) < 15) begin
        // Objects placed close together so that hits and misses both occur.
        for (int k = 0; k < 3; k++) begin
          base = int'($urandom_range(0, 4000)) - 2000;
          offs = int'($urandom_range(0, 1200)) - 600;
          p1[k*LANE +: LANE] = 16'(base);
          p2[k*LANE +: LANE] = 16'(base + offs);
          z1[k*LANE +: LANE] = 16'($urandom_range(0, 700));
          z2[k*LANE +: LANE] = 16'($urandom_range(0, 700));
        end
      end else begin
        p1 = random_word();
        p2 = random_word();
        z1 = random_word();
        z2 = random_word();
      end
      send_pair(s1, s2, p1, p2, z1, z2);
    end
  endtask

  // ---------------------------------------------------------------- output side

  always begin : drain_pacing
    int unsigned stall;
    @(negedge clk_i);
    if (rst_ni) begin
      stall = drain_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if ($urandom_range(0, 29) == 0) drain_calm = !drain_calm;
    end
  end

  always @(posedge clk_i) begin : result_check
    overlap_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_overlaps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: hit %0b pair_case %0d",
                   m_axis_tdata_o[0], m_axis_tuser_o);
      end else begin
        want = pending_overlaps.pop_front();
        if (m_axis_tdata_o[0] !== want.hit || m_axis_tuser_o !== want.pair_case) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: hit exp %0b got %0b, pair_case exp %0d got %0d",
                     want.hit, m_axis_tdata_o[0], want.pair_case, m_axis_tuser_o);
        end
      end
    end
  end

  // The pipeline never sits still for long when both sides make progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    m_axis_tready_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sphere_pairs();
    test_box_pairs();
    test_sphere_box_pairs();
    test_random_pairs();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_overlaps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    mismatches += pending_overlaps.size();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
